/* rtl/cbvu_pkg.sv */
// Shared types and constants for the complex block vector update.
// Holds the sequencer step codes, the jump conditions and the microcode table.
// No dependencies.
package cbvu_pkg;

   typedef enum logic [1:0] {
      FUNC_COEF   = 2'd0,
      FUNC_ROW    = 2'd1,
      FUNC_UPDATE = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      STEP_IDLE   = 3'd0,
      STEP_LOOP   = 3'd1,
      STEP_DRAIN1 = 3'd2,
      STEP_DRAIN2 = 3'd3,
      STEP_DRAIN3 = 3'd4,
      STEP_FINISH = 3'd5
   } step_type;

   typedef enum logic [1:0] {
      COND_NEVER     = 2'd0,
      COND_ALWAYS    = 2'd1,
      COND_NO_UPDATE = 2'd2,
      COND_MORE      = 2'd3
   } cond_type;

   typedef struct packed {
      logic     accept;
      logic     issue;
      logic     finish;
      logic     hold;
      cond_type cond;
      step_type target;
   } ctl_type;

   localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG = 32'h8000_0000;

   function automatic ctl_type microcode(step_type step);
      ctl_type w;
      w = '{accept: 1'b0, issue: 1'b0, finish: 1'b0, hold: 1'b0,
            cond: COND_NEVER, target: STEP_IDLE};
      case (step)
         STEP_IDLE: begin
            w.accept = 1'b1;
            w.cond   = COND_NO_UPDATE;
            w.target = STEP_IDLE;
         end
         STEP_LOOP: begin
            w.issue  = 1'b1;
            w.cond   = COND_MORE;
            w.target = STEP_LOOP;
         end
         STEP_DRAIN1, STEP_DRAIN2, STEP_DRAIN3: begin
            w.cond = COND_NEVER;
         end
         STEP_FINISH: begin
            w.finish = 1'b1;
            w.hold   = 1'b1;
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

/* rtl/complex_block_vector_update.sv */
// Top level of the complex block vector update, X += P*A one element at a time.
// Depends on cbvu_pkg (microcode, codes) and cbvu_ram (coefficient and row stores).
//
//   channel  ports                     direction  moves
//   req      req_valid / req_stall     in         load or update word
//   rsp      rsp_valid / rsp_stall     out        updated solution element
//   csr      csr_write_enable          in         vector count, no read-back
//
// A load word is taken in the idle step. An update word holds the sequencer
// through its loop, n being the active vector count (at most 16): the one
// complex multiplier takes one term per cycle, followed by three drain steps.
// Reset clears the sequencer, the valid flags and sets the count to 1; the
// stores are not cleared. A result waits in the output register while the next
// word is taken; a second result holds the sequencer in its final step.
module complex_block_vector_update #(
   parameter int unsigned MAX_VECTORS   = 16,
   parameter int unsigned FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [3:0]         req_source_index,
   input  logic [3:0]         req_column_index,
   input  logic signed [31:0] req_value_re,
   input  logic signed [31:0] req_value_im,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_re,
   output logic signed [31:0] rsp_result_im,
   output logic [3:0]         rsp_result_column,
   output logic               rsp_saturated,
   input  logic               csr_write_enable,
   input  logic [4:0]         csr_write_data
);

   import cbvu_pkg::*;

   localparam int unsigned CA_W  = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS * MAX_VECTORS) : 1;
   localparam int unsigned RB_W  = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
   localparam int unsigned ACC_W = 71 - FRACTION_BITS;
   localparam logic [4:0]  VC_CAP = 5'((MAX_VECTORS < 16) ? MAX_VECTORS : 16);
   localparam logic signed [63:0] HALF = (64'sd1 <<< FRACTION_BITS) >>> 1;

   // Sequencer
   step_type pc_ff, pc_in;
   ctl_type  ctl;
   logic     take, busy;

   // Control and datapath registers
   logic [4:0] count_ff;
   logic [4:0] n_ff, n_in;
   logic [3:0] j_ff, j_in;
   logic [3:0] col_ff;
   logic       rd_vld_ff, mul_vld_ff, term_vld_ff;
   logic       accepted, is_update, src_ok, col_ok, issue;
   logic [4:0] n_active;

   logic [63:0] coef_rd, row_rd;
   logic signed [31:0] ar, ai, pr, pi;
   logic signed [63:0] prod_rr_ff, prod_ii_ff, prod_ri_ff, prod_ir_ff;
   logic signed [63:0] rnd_rr, rnd_ii, rnd_ri, rnd_ir;
   logic signed [ACC_W-1:0] term_re_ff, term_im_ff;
   logic signed [ACC_W-1:0] acc_re_ff, acc_im_ff;

   logic        fits_re, fits_im;
   logic [31:0] sat_re, sat_im;
   logic        rsp_valid_ff;
   logic [31:0] rsp_re_ff, rsp_im_ff;
   logic [3:0]  rsp_col_ff;
   logic        rsp_sat_ff;

   // Sequencer: next step and strobes
   always_comb begin
      ctl  = microcode(pc_ff);
      busy = rsp_valid_ff && rsp_stall;
      case (ctl.cond)
         COND_NEVER:     take = 1'b0;
         COND_ALWAYS:    take = 1'b1;
         COND_NO_UPDATE: take = !(req_valid && req_func == FUNC_UPDATE);
         COND_MORE:      take = ({1'b0, j_ff} + 5'd1) < n_ff;
         default:        take = 1'b0;
      endcase
      if (ctl.hold && busy) begin
         pc_in = pc_ff;
      end else if (take) begin
         pc_in = ctl.target;
      end else begin
         pc_in = step_type'(pc_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign req_stall = !ctl.accept;
   assign accepted  = req_valid && ctl.accept;
   assign is_update = accepted && req_func == FUNC_UPDATE;
   assign src_ok    = 32'(req_source_index) < MAX_VECTORS;
   assign col_ok    = 32'(req_column_index) < MAX_VECTORS;
   assign n_active  = (count_ff > VC_CAP) ? VC_CAP : count_ff;
   assign issue     = ctl.issue && ({1'b0, j_ff} < n_ff);

   always_comb begin
      n_in = n_ff;
      j_in = j_ff;
      if (is_update) begin
         n_in = col_ok ? n_active : 5'd0;
         j_in = 4'd0;
      end else if (issue) begin
         j_in = j_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= 5'd1;
         rd_vld_ff   <= 1'b0;
         mul_vld_ff  <= 1'b0;
         term_vld_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            count_ff <= csr_write_data;
         end
         rd_vld_ff   <= issue;
         mul_vld_ff  <= rd_vld_ff;
         term_vld_ff <= mul_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      j_ff <= j_in;
      if (is_update) begin
         col_ff <= req_column_index;
      end
   end

   // Stores
   cbvu_ram #(
      .WIDTH (64),
      .DEPTH (MAX_VECTORS * MAX_VECTORS),
      .ADDR_W(CA_W)
   ) u_coef_ram (
      .clock  (clock),
      .wr_en  (accepted && req_func == FUNC_COEF && src_ok && col_ok),
      .wr_addr(CA_W'(32'(req_source_index) * MAX_VECTORS + 32'(req_column_index))),
      .wr_data({req_value_im, req_value_re}),
      .rd_en  (issue),
      .rd_addr(CA_W'(32'(j_ff) * MAX_VECTORS + 32'(col_ff))),
      .rd_data(coef_rd)
   );

   cbvu_ram #(
      .WIDTH (64),
      .DEPTH (MAX_VECTORS),
      .ADDR_W(RB_W)
   ) u_row_ram (
      .clock  (clock),
      .wr_en  (accepted && req_func == FUNC_ROW && src_ok),
      .wr_addr(RB_W'(32'(req_source_index))),
      .wr_data({req_value_im, req_value_re}),
      .rd_en  (issue),
      .rd_addr(RB_W'(32'(j_ff))),
      .rd_data(row_rd)
   );

   // Complex multiplier, rounding and accumulation
   assign ar = coef_rd[31:0];
   assign ai = coef_rd[63:32];
   assign pr = row_rd[31:0];
   assign pi = row_rd[63:32];

   always_ff @(posedge clock) begin
      prod_rr_ff <= ar * pr;
      prod_ii_ff <= ai * pi;
      prod_ri_ff <= ar * pi;
      prod_ir_ff <= ai * pr;
   end

   assign rnd_rr = (prod_rr_ff + HALF) >>> FRACTION_BITS;
   assign rnd_ii = (prod_ii_ff + HALF) >>> FRACTION_BITS;
   assign rnd_ri = (prod_ri_ff + HALF) >>> FRACTION_BITS;
   assign rnd_ir = (prod_ir_ff + HALF) >>> FRACTION_BITS;

   always_ff @(posedge clock) begin
      term_re_ff <= ACC_W'(rnd_rr) - ACC_W'(rnd_ii);
      term_im_ff <= ACC_W'(rnd_ri) + ACC_W'(rnd_ir);
      if (is_update) begin
         acc_re_ff <= ACC_W'(req_value_re);
         acc_im_ff <= ACC_W'(req_value_im);
      end else if (term_vld_ff) begin
         acc_re_ff <= acc_re_ff + term_re_ff;
         acc_im_ff <= acc_im_ff + term_im_ff;
      end
   end

   // Saturation and output register
   assign fits_re = (acc_re_ff[ACC_W-1:31] == '0) || (acc_re_ff[ACC_W-1:31] == '1);
   assign fits_im = (acc_im_ff[ACC_W-1:31] == '0) || (acc_im_ff[ACC_W-1:31] == '1);
   assign sat_re  = fits_re ? acc_re_ff[31:0] : (acc_re_ff[ACC_W-1] ? SAT_NEG : SAT_POS);
   assign sat_im  = fits_im ? acc_im_ff[31:0] : (acc_im_ff[ACC_W-1] ? SAT_NEG : SAT_POS);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.finish && !busy) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish && !busy) begin
         rsp_re_ff  <= sat_re;
         rsp_im_ff  <= sat_im;
         rsp_col_ff <= col_ff;
         rsp_sat_ff <= !fits_re || !fits_im;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_re     = rsp_re_ff;
   assign rsp_result_im     = rsp_im_ff;
   assign rsp_result_column = rsp_col_ff;
   assign rsp_saturated     = rsp_sat_ff;

   // Checks
   a_load_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pc_ff == STEP_FINISH))
      else $error("result loaded outside the final step");

   a_issue_from_loop: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(pc_ff == STEP_LOOP))
      else $error("store read issued outside the loop step");

   a_drained_at_finish: assert property (@(posedge clock) disable iff (reset)
      pc_ff == STEP_FINISH |-> !rd_vld_ff && !mul_vld_ff && !term_vld_ff)
      else $error("pipeline not drained at the final step");

endmodule

/* rtl/cbvu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the coefficient store and the row buffer; no dependencies.
module cbvu_ram #(
   parameter int unsigned WIDTH  = 64,
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sim/complex_block_vector_update_tb.sv */
// Self-checking testbench for complex_block_vector_update: loads and updates go
// through the valid/stall ports, vector count settings through the CSR write port,
// and each result word is checked against a predictor kept here. Depends on cbvu_pkg and the RTL only.
`timescale 1ns / 1ps

module complex_block_vector_update_tb;
   import cbvu_pkg::*;

   localparam int FRACTION_BITS    = 16;
   localparam int DRAIN_CYCLES     = 30;
   localparam int RANDOM_PER_PHASE = 90;
   localparam logic [1:0] FUNC_SPARE = 2'd3;
   localparam longint SUM_MAX = 64'sd2147483647;
   localparam longint SUM_MIN = -(64'sd2147483648);

   typedef struct {
      logic [1:0]         func;
      logic [3:0]         src;
      logic [3:0]         col;
      logic signed [31:0] re;
      logic signed [31:0] im;
   } bus_word_type;

   typedef struct {
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic [3:0]         col;
      logic               sat;
   } element_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_func = FUNC_COEF;
   logic [3:0]         req_source_index = 4'd0;
   logic [3:0]         req_column_index = 4'd0;
   logic signed [31:0] req_value_re = 32'sd0;
   logic signed [31:0] req_value_im = 32'sd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_result_re;
   logic signed [31:0] rsp_result_im;
   logic [3:0]         rsp_result_column;
   logic               rsp_saturated;
   logic               csr_write_enable = 1'b0;
   logic [4:0]         csr_write_data = 5'd0;

   bus_word_type       pending_words[$];
   element_type        expected_elements[$];
   bus_word_type       driven_word;
   element_type        want;
   int                 mismatch_count = 0;
   int                 queued_count = 0;
   bit                 calm = 1'b0;
   int                 send_gap = 0;
   int                 stall_run = 0;

   // predictor state
   logic [4:0]         model_count = 5'd1;
   logic signed [31:0] coef_re [16][16];
   logic signed [31:0] coef_im [16][16];
   logic signed [31:0] dir_re [16];
   logic signed [31:0] dir_im [16];

   // which entries the queued stimulus has written so far
   bit                 coef_loaded [16][16];
   bit                 dir_loaded [16];

   complex_block_vector_update i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_source_index  (req_source_index),
      .req_column_index  (req_column_index),
      .req_value_re      (req_value_re),
      .req_value_im      (req_value_im),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_re     (rsp_result_re),
      .rsp_result_im     (rsp_result_im),
      .rsp_result_column (rsp_result_column),
      .rsp_saturated     (rsp_saturated),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic longint round_q(input logic signed [31:0] a,
                                      input logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      if (FRACTION_BITS > 0)
         p = p + (64'sd1 <<< (FRACTION_BITS - 1));
      return p >>> FRACTION_BITS;
   endfunction

   function automatic logic signed [31:0] clip_part(input longint sum, inout logic sat);
      if (sum > SUM_MAX) begin
         sat = 1'b1;
         return SAT_POS;
      end
      if (sum < SUM_MIN) begin
         sat = 1'b1;
         return SAT_NEG;
      end
      return sum[31:0];
   endfunction

   function automatic element_type update_element(input bus_word_type w);
      element_type r;
      longint   acc_re;
      longint   acc_im;
      int       n;
      n = (model_count > 5'd16) ? 16 : int'(model_count);
      acc_re = longint'(w.re);
      acc_im = longint'(w.im);
      for (int j = 0; j < n; j++) begin
         acc_re = acc_re + round_q(coef_re[j][w.col], dir_re[j])
                         - round_q(coef_im[j][w.col], dir_im[j]);
         acc_im = acc_im + round_q(coef_re[j][w.col], dir_im[j])
                         + round_q(coef_im[j][w.col], dir_re[j]);
      end
      r.sat = 1'b0;
      r.re  = clip_part(acc_re, r.sat);
      r.im  = clip_part(acc_im, r.sat);
      r.col = w.col;
      return r;
   endfunction

   function automatic void apply_word(input bus_word_type w);
      case (w.func)
         FUNC_COEF: begin
            coef_re[w.src][w.col] = w.re;
            coef_im[w.src][w.col] = w.im;
         end
         FUNC_ROW: begin
            dir_re[w.src] = w.re;
            dir_im[w.src] = w.im;
         end
         FUNC_UPDATE: expected_elements.push_back(update_element(w));
         default: ;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall)
            apply_word(driven_word);
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() == 0) begin
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
               send_gap  <= $urandom_range(0, 2);
               req_valid <= 1'b0;
            end else begin
               driven_word      = pending_words.pop_front();
               req_func         <= driven_word.func;
               req_source_index <= driven_word.src;
               req_column_index <= driven_word.col;
               req_value_re     <= driven_word.re;
               req_value_im     <= driven_word.im;
               req_valid        <= 1'b1;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_elements.size() == 0) begin
               report_mismatch($sformatf("result word for column %0d with nothing expected",
                                         rsp_result_column));
            end else begin
               want = expected_elements.pop_front();
               if (rsp_result_column !== want.col)
                  report_mismatch($sformatf("column %0d, expected %0d",
                                            rsp_result_column, want.col));
               if (rsp_result_re !== want.re)
                  report_mismatch($sformatf("column %0d real %h, expected %h",
                                            want.col, rsp_result_re, want.re));
               if (rsp_result_im !== want.im)
                  report_mismatch($sformatf("column %0d imaginary %h, expected %h",
                                            want.col, rsp_result_im, want.im));
               if (rsp_saturated !== want.sat)
                  report_mismatch($sformatf("column %0d saturation flag %b, expected %b",
                                            want.col, rsp_saturated, want.sat));
            end
         end
         if (calm) begin
            rsp_stall <= 1'b0;
         end else if (stall_run != 0) begin
            stall_run <= stall_run - 1;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 5) == 0) begin
            stall_run <= $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(0, 7))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(0, 3))
               0: return SAT_POS;
               1: return SAT_NEG;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return $signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000;
      endcase
   endfunction

   task automatic queue_word(input logic [1:0] f, input int s, input int c,
                             input logic signed [31:0] vr, input logic signed [31:0] vi);
      bus_word_type w;
      w.func = f;
      w.src  = s[3:0];
      w.col  = c[3:0];
      w.re   = vr;
      w.im   = vi;
      pending_words.push_back(w);
      if (f == FUNC_COEF)
         coef_loaded[w.src][w.col] = 1'b1;
      if (f == FUNC_ROW)
         dir_loaded[w.src] = 1'b1;
      queued_count++;
   endtask

   // load whatever an update of column k would read but is not yet written
   task automatic fill_column(input int k, input int n);
      for (int j = 0; j < n; j++) begin
         if (!coef_loaded[j][k])
            queue_word(FUNC_COEF, j, k, rand_value(), rand_value());
         if (!dir_loaded[j])
            queue_word(FUNC_ROW, j, 0, rand_value(), rand_value());
      end
   endtask

   task automatic wait_until_quiet();
      @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_elements.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_vector_count(input logic [4:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_count = value;
   endtask

   task automatic run_phase(input logic [4:0] count_value, input bit no_idle);
      int n;
      int k;
      int target;
      wait_until_quiet();
      write_vector_count(count_value);
      @(negedge clock);
      calm   = no_idle;
      n      = (count_value > 5'd16) ? 16 : int'(count_value);
      target = queued_count + RANDOM_PER_PHASE;
      while (queued_count < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               for (int j = 0; j < n; j++)
                  queue_word(FUNC_ROW, j, $urandom_range(0, 15), rand_value(), rand_value());
               repeat ($urandom_range(1, 6)) begin
                  k = $urandom_range(0, 15);
                  fill_column(k, n);
                  queue_word(FUNC_UPDATE, $urandom_range(0, 15), k, rand_value(), rand_value());
               end
            end
            4, 5: queue_word(FUNC_COEF, $urandom_range(0, 15), $urandom_range(0, 15),
                             rand_value(), rand_value());
            6: queue_word(FUNC_ROW, $urandom_range(0, 15), $urandom_range(0, 15),
                          rand_value(), rand_value());
            7, 8: begin
               k = $urandom_range(0, 15);
               fill_column(k, n);
               queue_word(FUNC_UPDATE, $urandom_range(0, 15), k, rand_value(), rand_value());
            end
            default: queue_word(FUNC_SPARE, $urandom_range(0, 15), $urandom_range(0, 15),
                                rand_value(), rand_value());
         endcase
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // vector count still at its reset value of one
      queue_word(FUNC_SPARE, 15, 15, -32'sd1, -32'sd1);
      queue_word(FUNC_COEF, 0, 0, SAT_POS, SAT_POS);
      queue_word(FUNC_ROW, 0, 0, SAT_POS, SAT_POS);
      queue_word(FUNC_UPDATE, 0, 0, 32'sd0, 32'sd0);
      queue_word(FUNC_UPDATE, 15, 0, SAT_NEG, SAT_NEG);
      queue_word(FUNC_COEF, 0, 15, SAT_NEG, SAT_NEG);
      queue_word(FUNC_ROW, 0, 0, SAT_NEG, SAT_NEG);
      queue_word(FUNC_UPDATE, 0, 15, SAT_POS, SAT_POS);
      queue_word(FUNC_UPDATE, 0, 0, SAT_POS, SAT_NEG);
      // round half up on ties of both signs
      queue_word(FUNC_COEF, 0, 3, 32'sd1, -32'sd1);
      queue_word(FUNC_ROW, 0, 0, 32'sd32768, -32'sd32768);
      queue_word(FUNC_UPDATE, 0, 3, 32'sd0, 32'sd0);
      queue_word(FUNC_COEF, 0, 5, SAT_POS, 32'sd0);
      queue_word(FUNC_ROW, 0, 0, SAT_NEG, 32'sd0);
      queue_word(FUNC_UPDATE, 0, 5, SAT_NEG, 32'sd0);
      queue_word(FUNC_UPDATE, 0, 5, SAT_POS, SAT_POS);

      // zero vector count passes x straight through
      wait_until_quiet();
      write_vector_count(5'd0);
      @(negedge clock);
      queue_word(FUNC_UPDATE, 0, 9, SAT_NEG, SAT_POS);
      queue_word(FUNC_UPDATE, 0, 15, 32'sd1, -32'sd1);

      run_phase(5'd16, 1'b0);
      run_phase(5'd31, 1'b0);
      run_phase(5'd2, 1'b0);
      run_phase(5'd1, 1'b0);
      run_phase(5'($urandom_range(3, 15)), 1'b0);
      run_phase(5'd16, 1'b1);

      wait_until_quiet();
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

/* complex_block_vector_update.f */
rtl/cbvu_pkg.sv
rtl/cbvu_ram.sv
rtl/complex_block_vector_update.sv
sim/complex_block_vector_update_tb.sv
